// ----- hw/rtl/srfe_pkg.sv -----
// Shared types, constants and the CRC-8 byte step for the serial register frame engine.
`timescale 1ns / 1ps

package srfe_pkg;

	localparam int MAX_FRAME  = 64;
	localparam int WRAP_BYTES = 4;
	localparam int HDR_BYTES  = 3;
	localparam int PAY_DEPTH  = MAX_FRAME - WRAP_BYTES;
	localparam int LEN_LIMIT  = MAX_FRAME - WRAP_BYTES;
	localparam int CNT_W      = $clog2(MAX_FRAME + 1);
	localparam int PTR_W      = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	localparam logic [1:0] RD_LAST_IDX = 2'd2;
	localparam logic [1:0] WR_LAST_IDX = 2'd3;

	typedef enum logic [1:0] {
		FN_READ   = 2'd0,
		FN_WRITE  = 2'd1,
		FN_RXBYTE = 2'd2,
		FN_RXEND  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_ILLEGAL_LEN  = 2'd1,
		STS_LEN_MISMATCH = 2'd2,
		STS_CRC_FAIL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2
	} phase_t;

	// Source of the next result item
	typedef enum logic [1:0] {
		SEL_CMD  = 2'd0,
		SEL_STAT = 2'd1,
		SEL_PAY  = 2'd2
	} sel_t;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] module_address;
		logic [7:0] reg_address;
		logic [7:0] read_length;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [1:0] status;
		logic [6:0] received_count;
		logic       last;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic       accept;
		logic       emit;
		sel_t       sel;
		logic [1:0] idx;
		logic       fetch;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       rd_illegal;
		logic       end_none;
		logic       end_payload;
		logic       is_write;
		logic       load_ok;
		logic       pay_last;
	} dp_sts_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/srfe_ctrl.sv -----
// Controller state machine: sequences command bytes, status items and payload readout.
`timescale 1ns / 1ps

module srfe_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  srfe_pkg::dp_sts_t sts,
	output srfe_pkg::dp_cmd_t cmd
);
	import srfe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CMD   = 5'b00010,
		S_STAT  = 5'b00100,
		S_FETCH = 5'b01000,
		S_PAY   = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic [1:0] last_idx;

	assign cmd_ready = (state_q == S_IDLE);
	assign last_idx  = sts.is_write ? WR_LAST_IDX : RD_LAST_IDX;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		cmd.accept = 1'b0;
		cmd.emit   = 1'b0;
		cmd.sel    = SEL_CMD;
		cmd.idx    = idx_q;
		cmd.fetch  = 1'b0;
		case (state_q)
			S_IDLE: begin
				idx_d = 2'd0;
				if (cmd_valid) begin
					cmd.accept = 1'b1;
					case (sts.func)
						FN_READ:   state_d = sts.rd_illegal ? S_STAT : S_CMD;
						FN_WRITE:  state_d = S_CMD;
						FN_RXEND: begin
							if (sts.end_none) begin
								state_d = S_IDLE;
							end else if (sts.end_payload) begin
								state_d = S_FETCH;
							end else begin
								state_d = S_STAT;
							end
						end
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CMD: begin
				cmd.sel  = SEL_CMD;
				cmd.emit = sts.load_ok;
				if (sts.load_ok) begin
					if (idx_q == last_idx) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			S_STAT: begin
				cmd.sel  = SEL_STAT;
				cmd.emit = sts.load_ok;
				if (sts.load_ok) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				cmd.sel   = SEL_PAY;
				cmd.fetch = 1'b1;
				state_d   = S_PAY;
			end
			S_PAY: begin
				cmd.sel  = SEL_PAY;
				cmd.emit = sts.load_ok;
				if (sts.load_ok && sts.pay_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

// ----- hw/rtl/srfe_dp.sv -----
// Datapath: frame state, running CRC, payload memory and the result register.
`timescale 1ns / 1ps

module srfe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  srfe_pkg::in_item_t  cmd_item,
	output logic                res_valid,
	input  logic                res_ready,
	output srfe_pkg::out_item_t res_item,
	input  srfe_pkg::dp_cmd_t   cmd,
	output srfe_pkg::dp_sts_t   sts
);
	import srfe_pkg::*;

	phase_t           phase_q;
	logic [CNT_W-1:0] exp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       crc_q;
	logic [7:0]       fcb_q;
	logic [7:0]       sent_q;
	logic [7:0]       wcrc_q;
	in_item_t         item_q;
	logic [1:0]       stat_q;
	logic [CNT_W-1:0] stat_cnt_q;
	logic [PTR_W-1:0] pay_last_q;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] raddr;
	logic [7:0]       rdata_q;
	logic [7:0]       mem [PAY_DEPTH];
	out_item_t        out_q;
	logic             out_valid_q;

	logic             load_ok;
	logic             rx_take;
	logic             rx_store;
	logic             rx_full;
	logic             rd_crc_ok;
	logic [1:0]       end_status;
	logic [7:0]       cmd_byte;
	logic [7:0]       b0;
	logic             cmd_last;
	out_item_t        nxt;

	assign load_ok   = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	assign rx_full   = (cnt_q >= exp_q);
	assign rd_crc_ok = (crc_q == fcb_q);

	assign sts.func        = cmd_item.func;
	assign sts.rd_illegal  = ({1'b0, cmd_item.read_length} > 9'(LEN_LIMIT));
	assign sts.end_none    = (phase_q == PH_IDLE);
	assign sts.end_payload = (phase_q == PH_READ) && rx_full && rd_crc_ok &&
		(exp_q != CNT_W'(WRAP_BYTES));
	assign sts.is_write    = (item_q.func == FN_WRITE);
	assign sts.load_ok     = load_ok;
	assign sts.pay_last    = (ptr_q == pay_last_q);

	// Status an end of receive reports as a single item
	always_comb begin
		if (!rx_full) begin
			end_status = STS_LEN_MISMATCH;
		end else if (phase_q == PH_WRITE) begin
			end_status = (fcb_q != sent_q) ? STS_CRC_FAIL : STS_OK;
		end else if (!rd_crc_ok) begin
			end_status = STS_CRC_FAIL;
		end else begin
			end_status = STS_OK;
		end
	end

	assign rx_take  = cmd.accept && (cmd_item.func == FN_RXBYTE) &&
		(phase_q != PH_IDLE) && !rx_full;
	assign rx_store = rx_take && (cnt_q + CNT_W'(1) != exp_q) && (phase_q == PH_READ) &&
		(cnt_q >= CNT_W'(HDR_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			exp_q      <= '0;
			cnt_q      <= '0;
			crc_q      <= 8'h00;
			fcb_q      <= 8'h00;
			sent_q     <= 8'h00;
			wcrc_q     <= 8'h00;
			stat_q     <= STS_OK;
			stat_cnt_q <= '0;
			pay_last_q <= '0;
			ptr_q      <= '0;
		end else begin
			if (cmd.accept) begin
				case (cmd_item.func)
					FN_READ: begin
						stat_q     <= STS_ILLEGAL_LEN;
						stat_cnt_q <= '0;
						if (sts.rd_illegal) begin
							phase_q <= PH_IDLE;
						end else begin
							phase_q <= PH_READ;
							exp_q   <= CNT_W'(cmd_item.read_length) + CNT_W'(WRAP_BYTES);
							cnt_q   <= '0;
							crc_q   <= 8'h00;
							fcb_q   <= 8'h00;
						end
					end
					FN_WRITE: begin
						phase_q <= PH_WRITE;
						exp_q   <= CNT_W'(WRAP_BYTES);
						cnt_q   <= '0;
						crc_q   <= 8'h00;
						fcb_q   <= 8'h00;
						wcrc_q  <= 8'h00;
					end
					FN_RXBYTE: begin
						if (rx_take) begin
							if (cnt_q + CNT_W'(1) == exp_q) begin
								fcb_q <= cmd_item.data_byte;
							end else begin
								crc_q <= crc_step(crc_q, cmd_item.data_byte);
							end
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					default: begin
						stat_q     <= end_status;
						stat_cnt_q <= cnt_q;
						pay_last_q <= PTR_W'(exp_q - CNT_W'(WRAP_BYTES) - CNT_W'(1));
						phase_q    <= PH_IDLE;
					end
				endcase
			end
			// Accumulate the write CRC as its bytes go out; latch it with the CRC byte
			if (cmd.emit && (cmd.sel == SEL_CMD) && (item_q.func == FN_WRITE)) begin
				if (cmd.idx == WR_LAST_IDX) begin
					sent_q <= wcrc_q;
				end else begin
					wcrc_q <= crc_step(wcrc_q, cmd_byte);
				end
			end
			if (cmd.fetch) begin
				ptr_q <= '0;
			end else if (cmd.emit && (cmd.sel == SEL_PAY) && !sts.pay_last) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= cmd_item;
		end
	end

	// Payload memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rx_store) begin
			mem[PTR_W'(cnt_q - CNT_W'(HDR_BYTES))] <= cmd_item.data_byte;
		end
	end

	always_comb begin
		if (cmd.fetch) begin
			raddr = '0;
		end else if (cmd.emit && (cmd.sel == SEL_PAY) && !sts.pay_last) begin
			raddr = ptr_q + PTR_W'(1);
		end else begin
			raddr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign b0 = {item_q.module_address, (item_q.func == FN_WRITE)};

	always_comb begin
		case (cmd.idx)
			2'd0:    cmd_byte = b0;
			2'd1:    cmd_byte = item_q.reg_address;
			2'd2:    cmd_byte = sts.is_write ? item_q.data_byte : item_q.read_length;
			default: cmd_byte = wcrc_q;
		endcase
	end

	assign cmd_last = (cmd.idx == (sts.is_write ? WR_LAST_IDX : RD_LAST_IDX));

	always_comb begin
		nxt = '0;
		case (cmd.sel)
			SEL_CMD: begin
				nxt.kind     = KIND_TX;
				nxt.out_byte = cmd_byte;
				nxt.last     = cmd_last;
			end
			SEL_STAT: begin
				nxt.kind           = KIND_STATUS;
				nxt.status         = stat_q;
				nxt.received_count = 7'(stat_cnt_q);
				nxt.last           = 1'b1;
			end
			SEL_PAY: begin
				nxt.kind     = KIND_PAYLOAD;
				nxt.out_byte = rdata_q;
				if (sts.pay_last) begin
					nxt.status         = STS_OK;
					nxt.received_count = 7'(stat_cnt_q);
					nxt.last           = 1'b1;
				end
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= nxt;
		end
	end

endmodule

// ----- hw/rtl/serial_register_frame_engine.sv -----
// Serial register frame engine: command/receive items in, transmit/payload/status items out.
//
// Usage: drive one item on cmd_item with cmd_valid; it is taken when cmd_ready is high.
// Read and write commands produce the request bytes to transmit (kind TX), an illegal-length
// read one status item instead; received bytes update the frame CRC and fill the payload
// memory; a receive-end item with a frame pending produces either one status item or the
// payload bytes, the last of which carries status and count. Results leave through a single
// output register on res_valid/res_ready; the first result of an item reaches it after the
// controller state register, a payload readout after a fetch from the payload memory.
// Received bytes and items without results are taken one per cycle while cmd_ready is high.
// A command emits its three (read) or four (write) request bytes; a payload readout first
// fetches, then emits its N payload bytes. The controller emits one item per cycle through
// the output register and the payload memory read port while the receiver does not stall.
// cmd_ready is low while results of the current item are still being emitted; an item
// may be accepted while the last result still waits in the output register.
// A stalled receiver holds the output register and the sequencer until res_ready.
// Reset: asynchronous and active low; the engine returns idle with no frame pending.
// No clearing pass is needed: payload entries are always written before they are read.
`timescale 1ns / 1ps

module serial_register_frame_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  srfe_pkg::in_item_t  cmd_item,
	output logic                res_valid,
	input  logic                res_ready,
	output srfe_pkg::out_item_t res_item
);
	import srfe_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	srfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (dsts),
		.cmd       (dcmd)
	);

	srfe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cmd       (dcmd),
		.sts       (dsts)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench for the serial register frame engine: directed frames, then randomized frames.
`timescale 1ns / 1ps

module tb;
	import srfe_pkg::*;

	localparam int ITEMS     = 450;
	localparam int MAX_CYC   = 600000;
	localparam int DRAIN_CYC = 50;

	typedef enum {TAIL_AS_IS, TAIL_GOOD, TAIL_BAD} tail_mode_t;

	typedef struct {
		in_item_t   it;
		tail_mode_t tail;
		bit         typed;
		out_item_t  want;
	} dir_row_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	in_item_t  cmd_item  = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	out_item_t res_item;

	// Predictor state
	phase_t     ph       = PH_IDLE;
	logic [6:0] want_cnt = '0;
	logic [6:0] got_cnt  = '0;
	logic [7:0] run_crc  = '0;
	logic [7:0] tail_rx  = '0;
	logic [7:0] tx_crc   = '0;
	logic [7:0] pay_mem [PAY_DEPTH];

	out_item_t  step_results[$];
	out_item_t  due_results[$];
	dir_row_t   dir_rows[$];

	int n_acted     = 0;
	int n_bad       = 0;
	int n_seen      = 0;
	int cycles      = 0;
	int snd_idle    = 28;
	int rcv_idle    = 60;

	serial_register_frame_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// MSB-first CRC-8, one message bit per round
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[7] ^ b[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	function automatic out_item_t mk_out(kind_t k, logic [7:0] b, status_t s,
			logic [6:0] cnt, logic lst);
		out_item_t o;
		o.kind           = k;
		o.out_byte       = b;
		o.status         = s;
		o.received_count = cnt;
		o.last           = lst;
		return o;
	endfunction

	function automatic in_item_t mk_in(func_t f, logic [6:0] ma, logic [7:0] ra,
			logic [7:0] len, logic [7:0] d);
		in_item_t i;
		i.func           = f;
		i.module_address = ma;
		i.reg_address    = ra;
		i.read_length    = len;
		i.data_byte      = d;
		return i;
	endfunction

	// Byte that closes the current frame with a matching CRC
	function automatic logic [7:0] good_tail();
		return (ph == PH_WRITE) ? tx_crc : run_crc;
	endfunction

	// Advance the engine state by one item and collect the results it causes
	task automatic engine_step(input in_item_t it, output bit acted);
		logic [7:0] b0;
		logic [7:0] c;
		int         n;
		acted = 1'b1;
		step_results.delete();
		case (it.func)
			FN_READ: begin
				if (int'(it.read_length) + WRAP_BYTES > MAX_FRAME) begin
					ph = PH_IDLE;
					step_results.push_back(mk_out(KIND_STATUS, 8'h00, STS_ILLEGAL_LEN, 7'd0, 1'b1));
				end else begin
					step_results.push_back(mk_out(KIND_TX, {it.module_address, 1'b0}, STS_OK, 7'd0, 1'b0));
					step_results.push_back(mk_out(KIND_TX, it.reg_address, STS_OK, 7'd0, 1'b0));
					step_results.push_back(mk_out(KIND_TX, it.read_length, STS_OK, 7'd0, 1'b1));
					ph       = PH_READ;
					want_cnt = 7'(int'(it.read_length) + WRAP_BYTES);
					got_cnt  = '0;
					run_crc  = '0;
					tail_rx  = '0;
				end
			end
			FN_WRITE: begin
				b0 = {it.module_address, 1'b1};
				c  = crc8_byte(crc8_byte(crc8_byte(8'h00, b0), it.reg_address), it.data_byte);
				step_results.push_back(mk_out(KIND_TX, b0, STS_OK, 7'd0, 1'b0));
				step_results.push_back(mk_out(KIND_TX, it.reg_address, STS_OK, 7'd0, 1'b0));
				step_results.push_back(mk_out(KIND_TX, it.data_byte, STS_OK, 7'd0, 1'b0));
				step_results.push_back(mk_out(KIND_TX, c, STS_OK, 7'd0, 1'b1));
				ph       = PH_WRITE;
				want_cnt = 7'(WRAP_BYTES);
				got_cnt  = '0;
				run_crc  = '0;
				tail_rx  = '0;
				tx_crc   = c;
			end
			FN_RXBYTE: begin
				if (ph == PH_IDLE || got_cnt >= want_cnt) begin
					acted = 1'b0;
				end else begin
					if (got_cnt + 7'd1 == want_cnt) begin
						tail_rx = it.data_byte;
					end else begin
						run_crc = crc8_byte(run_crc, it.data_byte);
						if (ph == PH_READ && got_cnt >= 7'(HDR_BYTES)
								&& int'(got_cnt) - HDR_BYTES < PAY_DEPTH)
							pay_mem[int'(got_cnt) - HDR_BYTES] = it.data_byte;
					end
					got_cnt = got_cnt + 7'd1;
				end
			end
			default: begin
				if (ph == PH_IDLE) begin
					acted = 1'b0;
				end else if (got_cnt < want_cnt) begin
					step_results.push_back(mk_out(KIND_STATUS, 8'h00, STS_LEN_MISMATCH, got_cnt, 1'b1));
				end else if (ph == PH_WRITE) begin
					step_results.push_back(mk_out(KIND_STATUS, 8'h00,
						(tail_rx != tx_crc) ? STS_CRC_FAIL : STS_OK, got_cnt, 1'b1));
				end else if (run_crc != tail_rx) begin
					step_results.push_back(mk_out(KIND_STATUS, 8'h00, STS_CRC_FAIL, got_cnt, 1'b1));
				end else begin
					n = int'(want_cnt) - WRAP_BYTES;
					if (n > PAY_DEPTH)
						n = PAY_DEPTH;
					if (n <= 0)
						step_results.push_back(mk_out(KIND_STATUS, 8'h00, STS_OK, got_cnt, 1'b1));
					for (int i = 0; i < n; i++)
						step_results.push_back(mk_out(KIND_PAYLOAD, pay_mem[i], STS_OK,
							(i == n - 1) ? got_cnt : 7'd0, i == n - 1));
				end
				if (acted)
					ph = PH_IDLE;
			end
		endcase
	endtask

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		n_bad++;
	endtask

	task automatic check_field(input string name, input int got, input int exp);
		if (got != exp)
			flag_mismatch($sformatf("result %0d %s got %0d want %0d", n_seen, name, got, exp));
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t exp;
		if (due_results.size() == 0) begin
			flag_mismatch($sformatf("result %0d with nothing due: kind %0d byte %h", n_seen,
				got.kind, got.out_byte));
		end else begin
			exp = due_results.pop_front();
			check_field("kind", got.kind, exp.kind);
			check_field("out_byte", got.out_byte, exp.out_byte);
			check_field("status", got.status, exp.status);
			check_field("received_count", got.received_count, exp.received_count);
			check_field("last", got.last, exp.last);
		end
		n_seen++;
	endtask

	// Present one item, hold it until taken, then book its results
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		bit acted;
		if (n_acted < ITEMS / 3) begin
			snd_idle = 28;
			rcv_idle = 60;
		end else if (n_acted < 2 * ITEMS / 3) begin
			snd_idle = 60;
			rcv_idle = 28;
		end else begin
			snd_idle = 0;
			rcv_idle = 0;
		end
		if ($urandom_range(99) < snd_idle) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle);
		end
		cmd_item  <= it;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		engine_step(it, acted);
		if (typed) begin
			due_results.push_back(want);
		end else begin
			foreach (step_results[i])
				due_results.push_back(step_results[i]);
		end
		if (acted)
			n_acted++;
	endtask

	task automatic add_row(input in_item_t it, input tail_mode_t tm, input bit typed,
			input out_item_t want);
		dir_row_t r;
		r.it    = it;
		r.tail  = tm;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endtask

	task automatic random_frame();
		bit         is_rd;
		bit         bad;
		int         r;
		int         len;
		int         total;
		int         nbytes;
		logic [7:0] d;
		is_rd = $urandom_range(99) < 65;
		r     = $urandom_range(99);
		if (r < 5)
			len = $urandom_range(255, LEN_LIMIT + 1);
		else if (r < 12)
			len = LEN_LIMIT;
		else if (r < 20)
			len = 0;
		else
			len = $urandom_range(12, 1);
		send_item(mk_in(is_rd ? FN_READ : FN_WRITE, 7'($urandom), 8'($urandom), 8'(len),
			8'($urandom)), 1'b0, '0);
		if (is_rd && len > LEN_LIMIT)
			return;
		total = is_rd ? len + WRAP_BYTES : WRAP_BYTES;
		r     = $urandom_range(99);
		if (r < 12)
			nbytes = $urandom_range(total - 1, 0);
		else if (r < 20)
			nbytes = total + $urandom_range(3, 1);
		else
			nbytes = total;
		bad = $urandom_range(99) < 15;
		for (int i = 0; i < nbytes; i++) begin
			d = 8'($urandom);
			if (i == total - 1)
				d = bad ? good_tail() ^ 8'($urandom_range(255, 1)) : good_tail();
			send_item(mk_in(FN_RXBYTE, 7'($urandom), 8'($urandom), 8'($urandom), d), 1'b0, '0);
		end
		// Now and then drop the frame end so the next command abandons the transaction
		if ($urandom_range(99) >= 5)
			send_item(mk_in(FN_RXEND, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)),
				1'b0, '0);
	endtask

	// Result side: check at each accepting edge, stall at random
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res_item);
		res_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == MAX_CYC) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		out_item_t none;
		none = '0;
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'hff), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXEND, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_READ, 7'h7f, 8'hff, 8'(LEN_LIMIT + 1), 8'hff), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_ILLEGAL_LEN, 7'd0, 1'b1));
		add_row(mk_in(FN_READ, 7'h00, 8'h00, 8'hff, 8'h00), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_ILLEGAL_LEN, 7'd0, 1'b1));
		// Zero-length read, clean response plus one surplus byte
		add_row(mk_in(FN_READ, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_GOOD, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'haa), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXEND, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_OK, 7'd4, 1'b1));
		// Write with all-ones fields and a matching echo
		add_row(mk_in(FN_WRITE, 7'h7f, 8'hff, 8'hff, 8'hff), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h7f, 8'hff, 8'hff, 8'hff), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h7f, 8'hff, 8'hff, 8'hff), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h7f, 8'hff, 8'hff, 8'hff), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h7f, 8'hff, 8'hff, 8'h00), TAIL_GOOD, 1'b0, none);
		add_row(mk_in(FN_RXEND, 7'h7f, 8'hff, 8'hff, 8'hff), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_OK, 7'd4, 1'b1));
		// Write echo with a wrong CRC
		add_row(mk_in(FN_WRITE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h01), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_BAD, 1'b0, none);
		add_row(mk_in(FN_RXEND, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_CRC_FAIL, 7'd4, 1'b1));
		// Write abandoned by a read, then a short read response
		add_row(mk_in(FN_WRITE, 7'h01, 8'h02, 8'h00, 8'h03), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h03), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_READ, 7'h05, 8'h10, 8'h02, 8'h00), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXBYTE, 7'h00, 8'h00, 8'h00, 8'h0a), TAIL_AS_IS, 1'b0, none);
		add_row(mk_in(FN_RXEND, 7'h00, 8'h00, 8'h00, 8'h00), TAIL_AS_IS, 1'b1,
			mk_out(KIND_STATUS, 8'h00, STS_LEN_MISMATCH, 7'd1, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			it = dir_rows[i].it;
			if (dir_rows[i].tail == TAIL_GOOD)
				it.data_byte = good_tail();
			else if (dir_rows[i].tail == TAIL_BAD)
				it.data_byte = ~good_tail();
			send_item(it, dir_rows[i].typed, dir_rows[i].want);
		end

		while (n_acted < ITEMS) begin
			if ($urandom_range(99) < 10)
				send_item(mk_in(func_t'($urandom_range(3)), 7'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom)), 1'b0, '0);
			else
				random_frame();
		end
		cmd_valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (n_bad == 0 && due_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/srfe_pkg.sv
hw/rtl/srfe_ctrl.sv
hw/rtl/srfe_dp.sv
hw/rtl/serial_register_frame_engine.sv
tb/tb.sv
